/* src/cddnc_pkg.sv */
// shared types, constants and calendar tables for the civil date / day number converter
`timescale 1ns / 1ps

package cddnc_pkg;

    // largest year magnitude accepted; clamped so that every year fits the 15-bit field
    localparam int MAX_YEAR = 9999;
    localparam int YEAR_LIM = (MAX_YEAR > 16383) ? 16383 : MAX_YEAR;

    localparam int GREG_EPOCH = 719468;
    localparam int JUL_EPOCH  = 719470;
    localparam int FIRST_GREG_DAY = -79366;
    localparam int MAR_TO_JAN = 306;

    localparam int GREG_CYCLE = 146097;
    localparam int JUL_CYCLE  = 1461;

    // julian day numbers are biased by whole four-year cycles so the era stays positive
    localparam int JUL_ERA_BIAS  = 4096;
    localparam int JUL_YEAR_BIAS = 4 * JUL_ERA_BIAS;

    // pipeline depth from input register to output register
    localparam int NUM_STAGES = 9;
    localparam int LAST_STAGE = NUM_STAGES - 1;

    // request codes carried in s_tuser
    localparam logic REQ_TO_DAYS = 1'b0;
    localparam logic REQ_TO_DATE = 1'b1;

    localparam logic signed [15:0] YEAR_HI_S = 16'(YEAR_LIM);
    localparam logic signed [15:0] YEAR_LO_S = 16'(-YEAR_LIM);

    localparam logic signed [23:0] DN_HI = 24'(365 * YEAR_LIM + YEAR_LIM / 4 - YEAR_LIM / 100
        + YEAR_LIM / 400 + MAR_TO_JAN - GREG_EPOCH - 1);
    localparam logic signed [23:0] DN_LO = 24'(-365 * (YEAR_LIM + 1) - (YEAR_LIM + 4) / 4
        + MAR_TO_JAN - JUL_EPOCH);
    localparam logic signed [23:0] FIRST_GREG_S = 24'(FIRST_GREG_DAY);

    localparam logic signed [24:0] Z_OFS_GREG = 25'(GREG_EPOCH);
    localparam logic signed [24:0] Z_OFS_JUL  = 25'(JUL_EPOCH + JUL_ERA_BIAS * JUL_CYCLE);

    // reciprocal constants: floor(x / d) == (x * ceil(2^k / d)) >> k over the used range
    localparam int ERA_SHIFT     = 41;
    localparam int DIV100_SHIFT  = 21;
    localparam int DIV1460_SHIFT = 29;
    localparam int DIV365_SHIFT  = 27;

    localparam logic [30:0] R_ERA_GREG = 31'(((64'd1 << ERA_SHIFT) + 64'(GREG_CYCLE) - 64'd1)
        / 64'(GREG_CYCLE));
    localparam logic [30:0] R_ERA_JUL  = 31'(((64'd1 << ERA_SHIFT) + 64'(JUL_CYCLE) - 64'd1)
        / 64'(JUL_CYCLE));
    localparam logic [14:0] R_DIV100   = 15'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);
    localparam logic [18:0] R_DIV1460  = 19'(((64'd1 << DIV1460_SHIFT) + 64'd1459) / 64'd1460);
    localparam logic [18:0] R_DIV365   = 19'(((64'd1 << DIV365_SHIFT) + 64'd364) / 64'd365);

    // s_tdata layout, lowest field last
    typedef struct packed {
        logic signed [23:0] in_day_number;
        logic [4:0]         in_day;
        logic [3:0]         in_month;
        logic signed [14:0] in_year;
    } in_data_t;

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic [4:0]         out_day;
        logic [3:0]         out_month;
        logic signed [14:0] out_year;
        logic signed [23:0] out_day_number;
    } out_data_t;

    // days in a month of a common year, zero for codes that are not months
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

    // first day of month index mp, counted from march 1 (mp 0 is march)
    function automatic logic [8:0] march_start(input logic [3:0] mp);
        logic [8:0] days;
        case (mp)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd92;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd184;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd245;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd337;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

    // first day of calendar month m, counted from march 1
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] days;
        case (m)
            4'd1:    days = march_start(4'd10);
            4'd2:    days = march_start(4'd11);
            4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12:
                     days = march_start(m - 4'd3);
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

/* src/civil_date_day_number_converter_top.sv */
// civil date / day number converter: nine-stage streaming pipeline
`timescale 1ns / 1ps

// Converts between a calendar date and a signed day number, day 0 being 1970-01-01.
// The calendar is julian up to 1752-09-02 and gregorian from 1752-09-14, years are
// astronomical (year 0 and negative years exist) and limited to +/- cddnc_pkg::YEAR_LIM.
// s_tuser selects the request: REQ_TO_DAYS checks year, month and day and returns the
// day number, REQ_TO_DATE returns year, month and day for a day number. m_tuser flags an
// invalid date or an out-of-range day number; all result fields are then zero, and the
// fields that a request does not produce are always zero. One transfer is taken every
// cycle unless all stages are full and the output is stalled; a result passes stage
// registers 0 to 8 in order. The latency is set by the chain of reciprocal
// multiplications (era split, century correction, year of era), each followed by a
// register. Every stage holds its item while the next stage is full and held, so the
// input side keeps accepting until all nine stages carry an item.
module civil_date_day_number_converter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // in_year, in_month, in_day, in_day_number
    input  logic [0:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_day_number, out_year, out_month, out_day
    output logic [0:0]  m_tuser    // bad_input
);

    // ---------------------------------------------------------------- flow control
    logic [cddnc_pkg::LAST_STAGE:0] valid_reg, valid_next, stage_en;

    // a stage takes a new item when it is empty or its content moves on
    always_comb begin
        stage_en[cddnc_pkg::LAST_STAGE] = !valid_reg[cddnc_pkg::LAST_STAGE] || m_tready;
        for (int i = cddnc_pkg::LAST_STAGE - 1; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i + 1];
        end
        valid_next    = valid_reg;
        valid_next[0] = stage_en[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i <= cddnc_pkg::LAST_STAGE; i++) begin
            if (stage_en[i]) begin
                valid_next[i] = valid_reg[i - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[cddnc_pkg::LAST_STAGE];

    // ---------------------------------------------------------------- stage 0: input register
    cddnc_pkg::in_data_t s0_data_reg;
    logic                s0_req_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s0_data_reg <= cddnc_pkg::in_data_t'(s_tdata);
            s0_req_reg  <= s_tuser[0];
        end
    end

    // ---------------------------------------------------------------- stage 1
    // date side: year-day base sum and the century multiply
    // number side: range check, calendar choice and biased day count
    logic signed [15:0] s0_year_w;
    logic signed [15:0] s0_yy_w;
    logic signed [23:0] s0_dn_w;
    logic signed [24:0] s0_z_w;
    logic [3:0]         s0_month_w;
    logic [4:0]         s0_day_w;

    logic               s1_mle2_next, s1_greg_next, s1_yok_next, s1_g_next, s1_dnok_next;
    logic signed [25:0] s1_base_next;
    logic [28:0]        s1_p100_next;

    logic               s1_req_reg, s1_mle2_reg, s1_greg_reg, s1_yok_reg;
    logic               s1_g_reg, s1_dnok_reg;
    logic signed [14:0] s1_year_reg;
    logic [3:0]         s1_month_reg;
    logic [4:0]         s1_day_reg;
    logic signed [25:0] s1_base_reg;
    logic [28:0]        s1_p100_reg;
    logic [22:0]        s1_z_reg;

    always_comb begin
        s0_year_w  = $signed({s0_data_reg.in_year[14], s0_data_reg.in_year});
        s0_month_w = s0_data_reg.in_month;
        s0_day_w   = s0_data_reg.in_day;

        // january and february count with the previous year
        s1_mle2_next = (s0_month_w == 4'd1) || (s0_month_w == 4'd2);
        s0_yy_w      = s0_year_w - 16'(s1_mle2_next);
        s1_base_next = 26'(s0_yy_w) * 26'sd365 + 26'(s0_yy_w >>> 2)
                     + 26'(cddnc_pkg::month_start(s0_month_w)) + 26'(s0_day_w) - 26'sd1;

        s1_greg_next = (s0_year_w > 16'sd1752)
                    || ((s0_year_w == 16'sd1752)
                        && ((s0_month_w > 4'd9) || ((s0_month_w == 4'd9) && (s0_day_w >= 5'd14))));
        s1_yok_next  = (s0_year_w >= cddnc_pkg::YEAR_LO_S) && (s0_year_w <= cddnc_pkg::YEAR_HI_S);
        // only meaningful for positive years, where the low 14 bits hold the year
        s1_p100_next = 29'(s0_data_reg.in_year[13:0]) * 29'(cddnc_pkg::R_DIV100);

        s0_dn_w      = $signed(s0_data_reg.in_day_number);
        s1_dnok_next = (s0_dn_w >= cddnc_pkg::DN_LO) && (s0_dn_w <= cddnc_pkg::DN_HI);
        s1_g_next    = s0_dn_w >= cddnc_pkg::FIRST_GREG_S;
        s0_z_w       = 25'(s0_dn_w) + (s1_g_next ? cddnc_pkg::Z_OFS_GREG : cddnc_pkg::Z_OFS_JUL);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            s1_req_reg   <= s0_req_reg;
            s1_year_reg  <= s0_data_reg.in_year;
            s1_month_reg <= s0_month_w;
            s1_day_reg   <= s0_day_w;
            s1_mle2_reg  <= s1_mle2_next;
            s1_base_reg  <= s1_base_next;
            s1_greg_reg  <= s1_greg_next;
            s1_yok_reg   <= s1_yok_next;
            s1_p100_reg  <= s1_p100_next;
            s1_g_reg     <= s1_g_next;
            s1_dnok_reg  <= s1_dnok_next;
            s1_z_reg     <= s0_z_w[22:0];
        end
    end

    // ---------------------------------------------------------------- stage 2
    // date side finishes here; number side multiplies by the era reciprocal
    logic [7:0]         s1_q100_w, s1_qyy_w;
    logic               s1_rem0_w, s1_jleap_w, s1_leap_w, s1_gap_w, s1_ok_w;
    logic [4:0]         s1_len_w;
    logic signed [25:0] s1_dn_greg_w, s1_dn_jul_w, s1_dn_sel_w;

    logic [23:0]        s2_dn_next;
    logic               s2_bad_next;
    logic [53:0]        s2_pera_next;

    logic               s2_req_reg, s2_bad_reg, s2_g_reg;
    logic [23:0]        s2_dn_reg;
    logic [53:0]        s2_pera_reg;
    logic [22:0]        s2_z_reg;

    always_comb begin
        s1_q100_w  = s1_p100_reg[cddnc_pkg::DIV100_SHIFT +: 8];
        s1_rem0_w  = (14'(s1_q100_w) * 14'd100) == s1_year_reg[13:0];
        s1_jleap_w = s1_year_reg[1:0] == 2'b00;
        if (s1_year_reg > 15'sd1752) begin
            s1_leap_w = (s1_jleap_w && !s1_rem0_w) || (s1_rem0_w && (s1_q100_w[1:0] == 2'b00));
        end else begin
            s1_leap_w = s1_jleap_w;
        end
        s1_len_w = cddnc_pkg::month_len(s1_month_reg)
                 + 5'((s1_month_reg == 4'd2) && s1_leap_w);
        // the eleven days dropped at the calendar switch
        s1_gap_w = (s1_year_reg == 15'sd1752) && (s1_month_reg == 4'd9)
                && (s1_day_reg > 5'd2) && (s1_day_reg < 5'd14);
        s1_ok_w  = s1_yok_reg && (s1_month_reg >= 4'd1) && (s1_month_reg <= 4'd12)
                && (s1_day_reg != 5'd0) && (s1_day_reg <= s1_len_w) && !s1_gap_w;

        // century count of the march-based year
        s1_qyy_w     = s1_q100_w - 8'(s1_mle2_reg && s1_rem0_w);
        s1_dn_greg_w = s1_base_reg - 26'(s1_qyy_w) + 26'(s1_qyy_w >> 2)
                     - 26'(cddnc_pkg::GREG_EPOCH);
        s1_dn_jul_w  = s1_base_reg - 26'(cddnc_pkg::JUL_EPOCH);
        s1_dn_sel_w  = s1_greg_reg ? s1_dn_greg_w : s1_dn_jul_w;

        s2_dn_next   = (s1_ok_w && (s1_req_reg == cddnc_pkg::REQ_TO_DAYS))
                     ? s1_dn_sel_w[23:0] : 24'd0;
        s2_bad_next  = (s1_req_reg == cddnc_pkg::REQ_TO_DATE) ? !s1_dnok_reg : !s1_ok_w;
        s2_pera_next = 54'(s1_z_reg)
                     * 54'(s1_g_reg ? cddnc_pkg::R_ERA_GREG : cddnc_pkg::R_ERA_JUL);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            s2_req_reg  <= s1_req_reg;
            s2_bad_reg  <= s2_bad_next;
            s2_dn_reg   <= s2_dn_next;
            s2_pera_reg <= s2_pera_next;
            s2_g_reg    <= s1_g_reg;
            s2_z_reg    <= s1_z_reg;
        end
    end

    // ---------------------------------------------------------------- stage 3: era and day of era
    logic [12:0] s2_era_w;
    logic [30:0] s2_span_w, s2_doe_w;

    logic        s3_req_reg, s3_bad_reg, s3_g_reg;
    logic [23:0] s3_dn_reg;
    logic [17:0] s3_doe_reg;
    logic [12:0] s3_era_reg;

    always_comb begin
        s2_era_w  = s2_pera_reg[cddnc_pkg::ERA_SHIFT +: 13];
        s2_span_w = 31'(s2_era_w)
                  * (s2_g_reg ? 31'(cddnc_pkg::GREG_CYCLE) : 31'(cddnc_pkg::JUL_CYCLE));
        s2_doe_w  = 31'(s2_z_reg) - s2_span_w;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            s3_req_reg <= s2_req_reg;
            s3_bad_reg <= s2_bad_reg;
            s3_dn_reg  <= s2_dn_reg;
            s3_g_reg   <= s2_g_reg;
            s3_era_reg <= s2_era_w;
            s3_doe_reg <= s2_doe_w[17:0];
        end
    end

    // ---------------------------------------------------------------- stage 4: leap corrections
    logic [36:0] s4_p1460_next;
    logic [2:0]  s4_c36524_next;
    logic        s4_e146096_next;

    logic        s4_req_reg, s4_bad_reg, s4_g_reg, s4_e146096_reg;
    logic [23:0] s4_dn_reg;
    logic [17:0] s4_doe_reg;
    logic [12:0] s4_era_reg;
    logic [36:0] s4_p1460_reg;
    logic [2:0]  s4_c36524_reg;

    always_comb begin
        s4_p1460_next   = 37'(s3_doe_reg) * 37'(cddnc_pkg::R_DIV1460);
        // quotient by 36524 is at most four, found by comparison
        s4_c36524_next  = 3'(s3_doe_reg >= 18'd36524) + 3'(s3_doe_reg >= 18'd73048)
                        + 3'(s3_doe_reg >= 18'd109572) + 3'(s3_doe_reg >= 18'd146096);
        s4_e146096_next = s3_doe_reg == 18'd146096;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            s4_req_reg     <= s3_req_reg;
            s4_bad_reg     <= s3_bad_reg;
            s4_dn_reg      <= s3_dn_reg;
            s4_g_reg       <= s3_g_reg;
            s4_era_reg     <= s3_era_reg;
            s4_doe_reg     <= s3_doe_reg;
            s4_p1460_reg   <= s4_p1460_next;
            s4_c36524_reg  <= s4_c36524_next;
            s4_e146096_reg <= s4_e146096_next;
        end
    end

    // ---------------------------------------------------------------- stage 5: corrected day count
    logic [17:0] s5_n_next;

    logic        s5_req_reg, s5_bad_reg, s5_g_reg;
    logic [23:0] s5_dn_reg;
    logic [17:0] s5_doe_reg, s5_n_reg;
    logic [12:0] s5_era_reg;

    always_comb begin
        s5_n_next = s4_doe_reg - 18'(s4_p1460_reg[cddnc_pkg::DIV1460_SHIFT +: 8]);
        if (s4_g_reg) begin
            s5_n_next = s5_n_next + 18'(s4_c36524_reg) - 18'(s4_e146096_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            s5_req_reg <= s4_req_reg;
            s5_bad_reg <= s4_bad_reg;
            s5_dn_reg  <= s4_dn_reg;
            s5_g_reg   <= s4_g_reg;
            s5_era_reg <= s4_era_reg;
            s5_doe_reg <= s4_doe_reg;
            s5_n_reg   <= s5_n_next;
        end
    end

    // ---------------------------------------------------------------- stage 6: year of era multiply
    logic        s6_req_reg, s6_bad_reg, s6_g_reg;
    logic [23:0] s6_dn_reg;
    logic [17:0] s6_doe_reg;
    logic [12:0] s6_era_reg;
    logic [36:0] s6_p365_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            s6_req_reg  <= s5_req_reg;
            s6_bad_reg  <= s5_bad_reg;
            s6_dn_reg   <= s5_dn_reg;
            s6_g_reg    <= s5_g_reg;
            s6_era_reg  <= s5_era_reg;
            s6_doe_reg  <= s5_doe_reg;
            s6_p365_reg <= 37'(s5_n_reg) * 37'(cddnc_pkg::R_DIV365);
        end
    end

    // ---------------------------------------------------------------- stage 7: year and day of year
    logic [8:0]  s6_yoe_w;
    logic [1:0]  s6_yoe100_w;
    logic [17:0] s6_used_w, s6_doy_w;
    logic [16:0] s7_yr_next;

    logic        s7_req_reg, s7_bad_reg;
    logic [23:0] s7_dn_reg;
    logic [8:0]  s7_doy_reg;
    logic [16:0] s7_yr_reg;

    always_comb begin
        s6_yoe_w    = s6_p365_reg[cddnc_pkg::DIV365_SHIFT +: 9];
        s6_yoe100_w = 2'(s6_yoe_w >= 9'd100) + 2'(s6_yoe_w >= 9'd200) + 2'(s6_yoe_w >= 9'd300);
        s6_used_w   = 18'(s6_yoe_w) * 18'd365;
        if (s6_g_reg) begin
            s6_used_w  = s6_used_w + 18'(s6_yoe_w >> 2) - 18'(s6_yoe100_w);
            s7_yr_next = 17'(s6_yoe_w) + 17'(s6_era_reg) * 17'd400;
        end else begin
            // undo the bias of whole four-year cycles
            s7_yr_next = 17'(s6_yoe_w) + 17'({s6_era_reg, 2'b00})
                       - 17'(cddnc_pkg::JUL_YEAR_BIAS);
        end
        s6_doy_w = s6_doe_reg - s6_used_w;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[7]) begin
            s7_req_reg <= s6_req_reg;
            s7_bad_reg <= s6_bad_reg;
            s7_dn_reg  <= s6_dn_reg;
            s7_doy_reg <= s6_doy_w[8:0];
            s7_yr_reg  <= s7_yr_next;
        end
    end

    // ---------------------------------------------------------------- stage 8: month split, output register
    logic [3:0]  s7_mp_w, s7_month_w;
    logic [8:0]  s7_dom_w;
    logic [16:0] s7_year_w;

    cddnc_pkg::out_data_t out_next, out_reg;
    logic                 bad_next, bad_reg;

    always_comb begin
        // march-based month index: count of month starts already passed
        s7_mp_w = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (s7_doy_reg >= cddnc_pkg::march_start(4'(i))) begin
                s7_mp_w = s7_mp_w + 4'd1;
            end
        end
        s7_dom_w   = s7_doy_reg - cddnc_pkg::march_start(s7_mp_w) + 9'd1;
        s7_month_w = (s7_mp_w < 4'd10) ? s7_mp_w + 4'd3 : s7_mp_w - 4'd9;
        s7_year_w  = s7_yr_reg + 17'(s7_month_w <= 4'd2);

        out_next = '0;
        bad_next = s7_bad_reg;
        if (s7_req_reg == cddnc_pkg::REQ_TO_DAYS) begin
            out_next.out_day_number = s7_dn_reg;
        end else if (!s7_bad_reg) begin
            out_next.out_year  = s7_year_w[14:0];
            out_next.out_month = s7_month_w;
            out_next.out_day   = s7_dom_w[4:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[8]) begin
            out_reg <= out_next;
            bad_reg <= bad_next;
        end
    end

    assign m_tdata    = out_reg;
    assign m_tuser[0] = bad_reg;

endmodule

/* src/cddnc_checker.sv */
// port-level assertions for the civil date / day number converter, bound to the top level
`timescale 1ns / 1ps

module cddnc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [0:0]  m_tuser
);

    cddnc_pkg::out_data_t out_w;
    logic                 in_xfer, out_xfer;
    logic [3:0]           pending_reg, pending_next;

    assign out_w    = cddnc_pkg::out_data_t'(m_tdata);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // items accepted whose results have not been taken yet
    always_comb begin
        pending_next = pending_reg + 4'(in_xfer) - 4'(out_xfer);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

    // no result without an accepted item
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer |-> pending_reg != 4'd0)
    else $error("result without a pending item");

    // never more items in flight than pipeline stages
    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 4'(cddnc_pkg::NUM_STAGES))
    else $error("more items in flight than stages");

    // a flagged result carries only zeros
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("flagged result has nonzero fields");

    // a result carries either a day number or a date, never both
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_w.out_day_number == '0)
                  || ((out_w.out_year == '0) && (out_w.out_month == '0) && (out_w.out_day == '0)))
    else $error("day number and date both present");

endmodule

bind civil_date_day_number_converter_top cddnc_checker u_cddnc_checker (.*);

/* tb/tb_top.sv */
// self-checking testbench for the civil date / day number converter
`timescale 1ns / 1ps

module tb_top;

    // calendar constants for the local conversion
    localparam longint YEAR_LIMIT  = cddnc_pkg::YEAR_LIM;
    localparam longint GREG_OFFSET = 719468;
    localparam longint JUL_OFFSET  = 719470;
    localparam longint FIRST_GREG  = -79366;

    typedef struct packed {
        logic signed [23:0] day_number;
        logic signed [14:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
        logic               bad;
    } conversion_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    conversion_t pending_results[$];
    int          mismatch_count = 0;
    int          month_days[1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    longint      serial_lo;
    longint      serial_hi;
    bit          src_gaps_en = 1'b1;
    bit          sink_stall_en = 1'b1;
    int          stall_left = 0;

    civil_date_day_number_converter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- calendar math

    function automatic longint floor_div(input longint a, input longint b);
        longint q;
        q = a / b;
        if (a % b < 0) q--;
        return q;
    endfunction

    // julian rule up to 1752, gregorian after
    function automatic bit leap_year(input longint y);
        bit julian;
        julian = (y & 3) == 0;
        if (y <= 1752) return julian;
        return (julian && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    // date assumed valid; years counted from march so leap day ends the year
    function automatic longint days_from_date(input longint y, input longint m, input longint d);
        longint yy, mp, doy;
        bit     greg;
        yy = y - ((m <= 2) ? 1 : 0);
        mp = (m + 9) % 12;
        doy = (153 * mp + 2) / 5 + d - 1;
        greg = y > 1752 || (y == 1752 && (m > 9 || (m == 9 && d >= 14)));
        if (greg)
            return 365 * yy + floor_div(yy, 4) - floor_div(yy, 100) + floor_div(yy, 400)
                + doy - GREG_OFFSET;
        return 365 * yy + floor_div(yy, 4) + doy - JUL_OFFSET;
    endfunction

    function automatic void date_from_days(input longint dn, output longint y,
                                           output longint m, output longint d);
        longint z, era, doe, yoe, doy, mp;
        if (dn >= FIRST_GREG) begin
            z = dn + GREG_OFFSET;
            era = floor_div(z, 146097);
            doe = z - era * 146097;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            y = yoe + era * 400;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        end else begin
            z = dn + JUL_OFFSET;
            era = floor_div(z, 1461);
            doe = z - era * 1461;
            yoe = (doe - doe / 1460) / 365;
            y = yoe + era * 4;
            doy = doe - 365 * yoe;
        end
        mp = (5 * doy + 2) / 153;
        d = doy - (153 * mp + 2) / 5 + 1;
        m = (mp < 10) ? mp + 3 : mp - 9;
        if (m <= 2) y++;
    endfunction

    function automatic conversion_t convert_request(input logic req,
                                                    input cddnc_pkg::in_data_t item);
        conversion_t r;
        longint      y, m, d, dn;
        longint      len;
        bit          ok;
        r = '0;
        if (req == cddnc_pkg::REQ_TO_DAYS) begin
            y = $signed(item.in_year);
            m = item.in_month;
            d = item.in_day;
            ok = y >= -YEAR_LIMIT && y <= YEAR_LIMIT && m >= 1 && m <= 12;
            if (ok) begin
                len = month_days[m];
                if (m == 2 && leap_year(y)) len = 29;
                if (d < 1 || d > len) ok = 1'b0;
                // days dropped at the calendar switch
                if (y == 1752 && m == 9 && d > 2 && d < 14) ok = 1'b0;
            end
            if (ok) r.day_number = 24'(days_from_date(y, m, d));
            else r.bad = 1'b1;
        end else begin
            dn = $signed(item.in_day_number);
            if (dn < serial_lo || dn > serial_hi) begin
                r.bad = 1'b1;
            end else begin
                date_from_days(dn, y, m, d);
                r.year = 15'(y);
                r.month = 4'(m);
                r.day = 5'(d);
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- item builders

    // mostly short gaps, a few long ones
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // unused day number field gets random bits
    function automatic cddnc_pkg::in_data_t date_item(input int y, input int m, input int d);
        cddnc_pkg::in_data_t item;
        item.in_year = 15'(y);
        item.in_month = 4'(m);
        item.in_day = 5'(d);
        item.in_day_number = 24'($urandom);
        return item;
    endfunction

    function automatic cddnc_pkg::in_data_t serial_item(input longint dn);
        cddnc_pkg::in_data_t item;
        item = cddnc_pkg::in_data_t'({$urandom, $urandom});
        item.in_day_number = 24'(dn);
        return item;
    endfunction

    // well-formed date, now and then around the switch year
    function automatic cddnc_pkg::in_data_t rand_date_item();
        int y, m, len;
        y = int'($urandom_range(2 * YEAR_LIMIT)) - int'(YEAR_LIMIT);
        case ($urandom_range(9))
            0: y = 1752;
            1: y = 1600 + int'($urandom_range(300));
            2: y = int'($urandom_range(16)) - 8;
            default: ;
        endcase
        m = $urandom_range(1, 12);
        if (y == 1752 && $urandom_range(1)) m = 9;
        len = month_days[m] + ((m == 2 && leap_year(y)) ? 1 : 0);
        return date_item(y, m, $urandom_range(1, len));
    endfunction

    function automatic cddnc_pkg::in_data_t rand_serial_item();
        longint dn;
        case ($urandom_range(9))
            0, 1: dn = FIRST_GREG - 400 + $urandom_range(800);
            2:    dn = serial_lo - 40 + $urandom_range(80);
            3:    dn = serial_hi - 40 + $urandom_range(80);
            default: dn = serial_lo + $urandom_range(int'(serial_hi - serial_lo));
        endcase
        return serial_item(dn);
    endfunction

    function automatic cddnc_pkg::in_data_t noise_item();
        return cddnc_pkg::in_data_t'({$urandom, $urandom});
    endfunction

    // ---------------------------------------------------------------- driving

    // one input transfer; valid stays high on return so a following item can go back to back
    task automatic send_item(input logic req, input cddnc_pkg::in_data_t item);
        int gap;
        gap = src_gaps_en ? random_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= item;
        s_tuser <= req;
        pending_results.push_back(convert_request(req, item));
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // result side backpressure
    always @(posedge aclk) begin
        if (!sink_stall_en) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(99) < 25) begin
            m_tready <= 1'b0;
            stall_left <= random_gap();
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- checking

    // sampled mid-cycle: a transfer seen here completes at the next rising edge
    always @(negedge aclk) begin
        cddnc_pkg::out_data_t got;
        conversion_t          want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h tuser %b",
                       m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.out_day_number !== want.day_number) begin
                    $error("out_day_number: expected %0d, actual %0d",
                           want.day_number, got.out_day_number);
                    mismatch_count++;
                end
                if (got.out_year !== want.year) begin
                    $error("out_year: expected %0d, actual %0d", want.year, got.out_year);
                    mismatch_count++;
                end
                if (got.out_month !== want.month) begin
                    $error("out_month: expected %0d, actual %0d", want.month, got.out_month);
                    mismatch_count++;
                end
                if (got.out_day !== want.day) begin
                    $error("out_day: expected %0d, actual %0d", want.day, got.out_day);
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.bad) begin
                    $error("bad_input: expected %0d, actual %0d", want.bad, m_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // leap rules on both sides of the switch, the dropped september days, year limits,
    // month and day codes outside the calendar
    task automatic test_date_edges();
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(1970, 1, 1));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(1752, 9, 2));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(1752, 9, 3));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(1752, 9, 13));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(1752, 9, 14));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(1700, 2, 29));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(1900, 2, 29));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(2000, 2, 29));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(-1, 2, 29));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(-4, 2, 29));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(int'(YEAR_LIMIT), 12, 31));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(-int'(YEAR_LIMIT), 1, 1));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(int'(YEAR_LIMIT) + 1, 1, 1));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(-16384, 1, 1));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(2024, 0, 10));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(2024, 15, 10));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(2024, 5, 0));
        send_item(cddnc_pkg::REQ_TO_DAYS, date_item(2024, 4, 31));
    endtask

    // range ends, the first gregorian day and the extremes of the 24-bit field
    task automatic test_serial_edges();
        send_item(cddnc_pkg::REQ_TO_DATE, serial_item(serial_lo - 1));
        send_item(cddnc_pkg::REQ_TO_DATE, serial_item(serial_lo));
        send_item(cddnc_pkg::REQ_TO_DATE, serial_item(serial_hi));
        send_item(cddnc_pkg::REQ_TO_DATE, serial_item(serial_hi + 1));
        send_item(cddnc_pkg::REQ_TO_DATE, serial_item(FIRST_GREG - 1));
        send_item(cddnc_pkg::REQ_TO_DATE, serial_item(FIRST_GREG));
        send_item(cddnc_pkg::REQ_TO_DATE, serial_item(-(64'sd1 << 23)));
        send_item(cddnc_pkg::REQ_TO_DATE, serial_item((64'sd1 << 23) - 1));
    endtask

    task automatic test_random_dates(input int count);
        repeat (count) send_item(cddnc_pkg::REQ_TO_DAYS, rand_date_item());
    endtask

    task automatic test_random_serials(input int count);
        repeat (count) send_item(cddnc_pkg::REQ_TO_DATE, rand_serial_item());
    endtask

    // every field bit toggles, both request kinds, mostly invalid dates
    task automatic test_random_noise(input int count);
        repeat (count) send_item(1'($urandom_range(1)), noise_item());
    endtask

    // full rate on both sides, mixed traffic
    task automatic test_back_to_back(input int count);
        src_gaps_en = 1'b0;
        sink_stall_en = 1'b0;
        repeat (count) begin
            case ($urandom_range(2))
                0: send_item(cddnc_pkg::REQ_TO_DAYS, rand_date_item());
                1: send_item(cddnc_pkg::REQ_TO_DATE, rand_serial_item());
                default: send_item(1'($urandom_range(1)), noise_item());
            endcase
        end
        src_gaps_en = 1'b1;
        sink_stall_en = 1'b1;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        serial_lo = days_from_date(-YEAR_LIMIT, 1, 1);
        serial_hi = days_from_date(YEAR_LIMIT, 12, 31);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_date_edges();
        test_serial_edges();
        // sender holds off until the pipeline has emptied
        wait_drained();
        test_random_dates(260);
        test_random_serials(260);
        test_back_to_back(100);
        test_random_noise(180);

        wait_drained();
        repeat (4 * cddnc_pkg::NUM_STAGES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
